// ----- hw/rtl/polynomial_warp_coordinate_gen_core_macros.svh -----
// assertion macros shared by the warp coordinate generator rtl
`ifndef POLYNOMIAL_WARP_COORDINATE_GEN_CORE_MACROS_SVH
`define POLYNOMIAL_WARP_COORDINATE_GEN_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PWCG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwcg assertion failed");

// next-cycle implication, checked out of reset
`define PWCG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwcg assertion failed");

`endif

// ----- hw/rtl/pwcg_pkg.sv -----
// shared types, constants and helpers of the warp coordinate generator
`default_nettype none
package pwcg_pkg;

	localparam int MAX_ORDER = 3;
	localparam int COORD_BITS = 12;
	localparam int PIX_W = 12;
	localparam int CW = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
	localparam int MAX_POW = 3;
	localparam int TERM_CNT = 10;
	localparam int NUM_AXES = 2;
	localparam int IDX_W = 4;
	localparam int COEFF_W = 64;
	localparam int HALF_W = 32;
	localparam int MONO_W = MAX_POW * CW;
	localparam int LO_W = HALF_W + MONO_W;
	localparam int HI_W = HALF_W + 1 + MONO_W;
	localparam int PROD_W = COEFF_W + MONO_W;
	localparam int ACC_W = PROD_W + 4;
	localparam int OUT_W = 32;
	localparam int FRAC_SHIFT = 32;
	localparam int ORD_W = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [ORD_W-1:0] ORDER_RESET = ORD_W'(1);
	localparam logic OP_LOAD = 1'b0;
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);
	localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

	typedef enum logic {
		KIND_LOAD,
		KIND_PIXEL
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [ORD_W-1:0] ord;
		logic axis;
		logic [IDX_W-1:0] idx;
		logic [COEFF_W-1:0] value;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic used;
		logic [1:0] px;
		logic [1:0] py;
	} term_t;

	// effective order: zero acts as one, above the maximum acts as the maximum
	function automatic logic [ORD_W-1:0] clamp_order(input logic [ORD_W-1:0] ord);
		logic [ORD_W-1:0] r;
		r = ord;
		if (ord == '0) r = ORD_W'(1);
		if (int'(ord) > MAX_ORDER) r = ORD_W'(MAX_ORDER);
		return r;
	endfunction

	// powers of x and y for term k, x power outer and y power inner
	function automatic term_t term_map(input logic [ORD_W-1:0] ord, input logic [IDX_W-1:0] k);
		term_t t;
		logic [IDX_W-1:0] n;
		t = '0;
		n = '0;
		for (int i = 0; i <= MAX_POW; i++) begin
			for (int j = 0; j <= MAX_POW; j++) begin
				if ((i + j) <= int'(ord)) begin
					if (n == k) begin
						t.used = 1'b1;
						t.px = 2'(i);
						t.py = 2'(j);
					end
					n = n + IDX_W'(1);
				end
			end
		end
		return t;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pwcg_front.sv -----
// front end: order register, request classification and queue push
`default_nettype none
module pwcg_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [pwcg_pkg::ORD_W-1:0] cfg_wdata,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic op,
	input  wire logic coeff_axis,
	input  wire logic [pwcg_pkg::IDX_W-1:0] coeff_index,
	input  wire logic [pwcg_pkg::COEFF_W-1:0] coeff_value,
	input  wire logic [pwcg_pkg::PIX_W-1:0] pixel_col,
	input  wire logic [pwcg_pkg::PIX_W-1:0] pixel_row,
	input  wire pwcg_pkg::qstat_t qstat,
	output logic push,
	output pwcg_pkg::item_t item
);

	logic [pwcg_pkg::ORD_W-1:0] poly_order_q;
	logic keep;

	// order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_order_q <= pwcg_pkg::ORDER_RESET;
		end else if (cfg_we) begin
			poly_order_q <= cfg_wdata;
		end
	end

	// classify: loads past the table are dropped here
	always_comb begin
		item.kind = (op == pwcg_pkg::OP_LOAD) ? pwcg_pkg::KIND_LOAD : pwcg_pkg::KIND_PIXEL;
		item.ord = pwcg_pkg::clamp_order(poly_order_q);
		item.axis = coeff_axis;
		item.idx = coeff_index;
		item.value = coeff_value;
		item.x = pixel_col[pwcg_pkg::CW-1:0];
		item.y = pixel_row[pwcg_pkg::CW-1:0];
		keep = (item.kind == pwcg_pkg::KIND_PIXEL) ||
			(int'(coeff_index) < pwcg_pkg::TERM_CNT);
	end

	assign in_stall = qstat.full;
	assign push = in_valid && !in_stall && keep;

endmodule
`default_nettype wire

// ----- hw/rtl/pwcg_queue.sv -----
// short request queue between front end and evaluation pipeline
`default_nettype none
`include "polynomial_warp_coordinate_gen_core_macros.svh"
module pwcg_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire pwcg_pkg::item_t item_in,
	input  wire logic pop,
	output pwcg_pkg::item_t item_out,
	output pwcg_pkg::qstat_t qstat
);

	pwcg_pkg::item_t mem_q [pwcg_pkg::QUEUE_DEPTH];
	logic [pwcg_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [pwcg_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [pwcg_pkg::QCNT_W-1:0] cnt_q;

	// storage, pointers wrap at the power-of-two depth
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + pwcg_pkg::QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + pwcg_pkg::QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + pwcg_pkg::QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - pwcg_pkg::QCNT_W'(1);
		end
	end

	assign item_out = mem_q[rd_ptr_q];
	assign qstat.full = (cnt_q == pwcg_pkg::QCNT_W'(pwcg_pkg::QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);

	`PWCG_ASSERT_NOW(a_no_push_full, push, !qstat.full)
	`PWCG_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty)

endmodule
`default_nettype wire

// ----- hw/rtl/pwcg_back.sv -----
// back end: monomials, coefficient table, products, adder tree, rounding
`default_nettype none
`include "polynomial_warp_coordinate_gen_core_macros.svh"
module pwcg_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pwcg_pkg::qstat_t qstat,
	input  wire pwcg_pkg::item_t item,
	output logic pop,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [pwcg_pkg::OUT_W-1:0] src_x_q16,
	output logic signed [pwcg_pkg::OUT_W-1:0] src_y_q16,
	output logic saturated
);

	localparam int NA = pwcg_pkg::NUM_AXES;
	localparam int NT = pwcg_pkg::TERM_CNT;
	localparam int CW = pwcg_pkg::CW;
	localparam int MW = pwcg_pkg::MONO_W;
	localparam int AW = pwcg_pkg::ACC_W;
	localparam int PW = pwcg_pkg::PROD_W;
	localparam int HW = pwcg_pkg::HALF_W;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic out_valid_q;

	// stage 1..3 payload
	pwcg_pkg::item_t it_s1;
	pwcg_pkg::kind_t kind_s2, kind_s3;
	logic [pwcg_pkg::ORD_W-1:0] ord_s2;
	logic axis_s2, axis_s3;
	logic [pwcg_pkg::IDX_W-1:0] idx_s2, idx_s3;
	logic [pwcg_pkg::COEFF_W-1:0] val_s2, val_s3;
	logic [CW-1:0] x_s2, y_s2;
	logic [2*CW-1:0] x2_s2, xy_s2, y2_s2;
	logic [MW-1:0] mono_s3 [NT];

	// coefficient table
	logic [pwcg_pkg::COEFF_W-1:0] coeff_q [NA][NT];

	// product and tree payload
	logic [pwcg_pkg::LO_W-1:0] lo_s4 [NA][NT];
	logic signed [pwcg_pkg::HI_W-1:0] hi_s4 [NA][NT];
	logic signed [AW-1:0] t_s5 [NA][NT];
	logic signed [AW-1:0] p_s6 [NA][5];
	logic signed [AW-1:0] p_s7 [NA][3];
	logic signed [AW-1:0] p_s8 [NA][2];
	logic signed [AW-1:0] sum_s9 [NA];
	logic [pwcg_pkg::OUT_W-1:0] res_q [NA];
	logic sat_q;

	// combinational results
	logic [2*CW-1:0] x2_c, xy_c, y2_c;
	logic [MW-1:0] pw_c [4][4];
	logic [MW-1:0] mono_c [NT];
	logic [pwcg_pkg::LO_W-1:0] lo_c [NA][NT];
	logic signed [pwcg_pkg::HI_W-1:0] hi_c [NA][NT];
	logic signed [AW-1:0] t_c [NA][NT];
	logic [AW-1:0] rnd_c [NA];
	logic [pwcg_pkg::OUT_W-1:0] res_c [NA];
	logic [NA-1:0] clip_c;
	logic [PW-1:0] prod_c [NA][NT];
	pwcg_pkg::term_t tm;

	// the whole pipeline advances unless a finished result is held
	assign en = !(out_valid_q && out_stall);
	assign pop = !qstat.empty && en;

	// stage 1: squares and cross product
	always_comb begin
		x2_c = (2*CW)'(it_s1.x) * (2*CW)'(it_s1.x);
		xy_c = (2*CW)'(it_s1.x) * (2*CW)'(it_s1.y);
		y2_c = (2*CW)'(it_s1.y) * (2*CW)'(it_s1.y);
	end

	// stage 2: cubes, then monomial per term for the current order
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				pw_c[i][j] = '0;
			end
		end
		pw_c[0][0] = MW'(1);
		pw_c[0][1] = MW'(y_s2);
		pw_c[0][2] = MW'(y2_s2);
		pw_c[0][3] = MW'(y2_s2) * MW'(y_s2);
		pw_c[1][0] = MW'(x_s2);
		pw_c[1][1] = MW'(xy_s2);
		pw_c[1][2] = MW'(xy_s2) * MW'(y_s2);
		pw_c[2][0] = MW'(x2_s2);
		pw_c[2][1] = MW'(x2_s2) * MW'(y_s2);
		pw_c[3][0] = MW'(x2_s2) * MW'(x_s2);
		for (int k = 0; k < NT; k++) begin
			tm = pwcg_pkg::term_map(ord_s2, pwcg_pkg::IDX_W'(k));
			mono_c[k] = tm.used ? pw_c[tm.px][tm.py] : '0;
		end
	end

	// stage 3: split products, low half unsigned, high half signed
	always_comb begin
		for (int a = 0; a < NA; a++) begin
			for (int k = 0; k < NT; k++) begin
				lo_c[a][k] = pwcg_pkg::LO_W'(coeff_q[a][k][HW-1:0]) *
					pwcg_pkg::LO_W'(mono_s3[k]);
				hi_c[a][k] = pwcg_pkg::HI_W'($signed(coeff_q[a][k][2*HW-1:HW])) *
					pwcg_pkg::HI_W'($signed({1'b0, mono_s3[k]}));
			end
		end
	end

	// stage 4: recombine halves into one term
	always_comb begin
		for (int a = 0; a < NA; a++) begin
			for (int k = 0; k < NT; k++) begin
				prod_c[a][k] = {hi_s4[a][k][PW-HW-1:0], {HW{1'b0}}} + PW'(lo_s4[a][k]);
				t_c[a][k] = AW'($signed(prod_c[a][k]));
			end
		end
	end

	// output: round half up at the q16 point and clip to 32 bits
	always_comb begin
		for (int a = 0; a < NA; a++) begin
			rnd_c[a] = sum_s9[a] + pwcg_pkg::ROUND_HALF;
			clip_c[a] = !((&rnd_c[a][AW-1:pwcg_pkg::FRAC_SHIFT+pwcg_pkg::OUT_W-1]) ||
				!(|rnd_c[a][AW-1:pwcg_pkg::FRAC_SHIFT+pwcg_pkg::OUT_W-1]));
			if (!clip_c[a]) begin
				res_c[a] = rnd_c[a][pwcg_pkg::FRAC_SHIFT +: pwcg_pkg::OUT_W];
			end else if (rnd_c[a][AW-1]) begin
				res_c[a] = pwcg_pkg::SAT_MIN;
			end else begin
				res_c[a] = pwcg_pkg::SAT_MAX;
			end
		end
	end

	// coefficient table, written when a load reaches stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NA; a++) begin
				for (int k = 0; k < NT; k++) begin
					coeff_q[a][k] <= '0;
				end
			end
		end else if (v_s3 && kind_s3 == pwcg_pkg::KIND_LOAD) begin
			coeff_q[axis_s3][idx_s3] <= val_s3;
		end
	end

	// stage valids; loads leave the pipeline after stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && kind_s3 == pwcg_pkg::KIND_PIXEL;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			out_valid_q <= v_s9;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= item;
			kind_s2 <= it_s1.kind;
			ord_s2 <= it_s1.ord;
			axis_s2 <= it_s1.axis;
			idx_s2 <= it_s1.idx;
			val_s2 <= it_s1.value;
			x_s2 <= it_s1.x;
			y_s2 <= it_s1.y;
			x2_s2 <= x2_c;
			xy_s2 <= xy_c;
			y2_s2 <= y2_c;
			kind_s3 <= kind_s2;
			axis_s3 <= axis_s2;
			idx_s3 <= idx_s2;
			val_s3 <= val_s2;
			mono_s3 <= mono_c;
			lo_s4 <= lo_c;
			hi_s4 <= hi_c;
			t_s5 <= t_c;
			for (int a = 0; a < NA; a++) begin
				for (int i = 0; i < 5; i++) begin
					p_s6[a][i] <= t_s5[a][2*i] + t_s5[a][2*i+1];
				end
				p_s7[a][0] <= p_s6[a][0] + p_s6[a][1];
				p_s7[a][1] <= p_s6[a][2] + p_s6[a][3];
				p_s7[a][2] <= p_s6[a][4];
				p_s8[a][0] <= p_s7[a][0] + p_s7[a][1];
				p_s8[a][1] <= p_s7[a][2];
				sum_s9[a] <= p_s8[a][0] + p_s8[a][1];
			end
			res_q <= res_c;
			sat_q <= |clip_c;
		end
	end

	assign out_valid = out_valid_q;
	assign src_x_q16 = $signed(res_q[0]);
	assign src_y_q16 = $signed(res_q[1]);
	assign saturated = sat_q;

	`PWCG_ASSERT_NOW(a_sat_at_limit, out_valid_q && sat_q, (res_q[0] == pwcg_pkg::SAT_MIN) || (res_q[0] == pwcg_pkg::SAT_MAX) || (res_q[1] == pwcg_pkg::SAT_MIN) || (res_q[1] == pwcg_pkg::SAT_MAX))
	`PWCG_ASSERT_NEXT(a_tail_held, v_s9 && !en, v_s9)

endmodule
`default_nettype wire

// ----- hw/rtl/polynomial_warp_coordinate_gen_core.sv -----
// Bivariate polynomial warp coordinate generator, order 1 to 3.
// Input channel (in_valid / in_stall): each request is either a coefficient
// load (op = 0) that writes one signed Q16.48 term of the x or y polynomial,
// or a pixel (op = 1) that yields one source coordinate pair in Q16.16.
// Loads with a term index of ten or more are taken and dropped.
// Output channel (out_valid / out_stall): one result per pixel, in order.
// Config: cfg_we writes poly_order; write it only while the block is idle.
// Throughput is one request per clock while out_stall does not hold the
// pipeline. Each pixel passes ten register stages behind the queue (input,
// squares, cubes, split 32-bit products, term join, four adder-tree levels
// and the rounding output register). Loads update the table in order.
// When out_stall holds a result, the whole pipeline freezes and the two-entry
// queue absorbs requests; in_stall rises once the queue is full.
// Reset clears the coefficient table to zero and sets the order to one.
`default_nettype none
module polynomial_warp_coordinate_gen_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [pwcg_pkg::ORD_W-1:0] cfg_wdata,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic op,
	input  wire logic coeff_axis,
	input  wire logic [pwcg_pkg::IDX_W-1:0] coeff_index,
	input  wire logic signed [pwcg_pkg::COEFF_W-1:0] coeff_value,
	input  wire logic [pwcg_pkg::PIX_W-1:0] pixel_col,
	input  wire logic [pwcg_pkg::PIX_W-1:0] pixel_row,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [pwcg_pkg::OUT_W-1:0] src_x_q16,
	output logic signed [pwcg_pkg::OUT_W-1:0] src_y_q16,
	output logic saturated
);

	pwcg_pkg::qstat_t qstat;
	pwcg_pkg::item_t push_item;
	pwcg_pkg::item_t head_item;
	logic push;
	logic pop;

	// request classification
	pwcg_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.coeff_axis(coeff_axis),
		.coeff_index(coeff_index),
		.coeff_value(coeff_value),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.qstat(qstat),
		.push(push),
		.item(push_item)
	);

	// decoupling queue
	pwcg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item_in(push_item),
		.pop(pop),
		.item_out(head_item),
		.qstat(qstat)
	);

	// evaluation pipeline
	pwcg_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.item(head_item),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.src_x_q16(src_x_q16),
		.src_y_q16(src_y_q16),
		.saturated(saturated)
	);

endmodule
`default_nettype wire

// ----- bench/polynomial_warp_coordinate_gen_core_tb.sv -----
// self-checking testbench for the polynomial warp coordinate generator core
`default_nettype none
module polynomial_warp_coordinate_gen_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pwcg_pkg::*;

	typedef struct {
		logic signed [OUT_W-1:0] sx;
		logic signed [OUT_W-1:0] sy;
		logic sat;
	} coord_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ORD_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic coeff_axis = 1'b0;
	logic [IDX_W-1:0] coeff_index = '0;
	logic signed [COEFF_W-1:0] coeff_value = '0;
	logic [PIX_W-1:0] pixel_col = '0;
	logic [PIX_W-1:0] pixel_row = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] src_x_q16;
	logic signed [OUT_W-1:0] src_y_q16;
	logic saturated;

	// model state
	logic signed [COEFF_W-1:0] coeff_mem [NUM_AXES][TERM_CNT];
	logic [ORD_W-1:0] order_reg = ORDER_RESET;
	coord_t coord_q[$];
	int err_cnt = 0;
	bit gaps_on = 1'b1;

	polynomial_warp_coordinate_gen_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .op(op),
		.coeff_axis(coeff_axis), .coeff_index(coeff_index),
		.coeff_value(coeff_value), .pixel_col(pixel_col), .pixel_row(pixel_row),
		.out_valid(out_valid), .out_stall(out_stall), .src_x_q16(src_x_q16),
		.src_y_q16(src_y_q16), .saturated(saturated)
	);

	always #5 clk = ~clk;

	// round Q16.48 sum to Q16.16 with saturation
	function automatic logic signed [OUT_W-1:0] round_q16(input logic signed [127:0] acc,
			inout logic sat);
		logic signed [127:0] r;
		r = (acc + (128'sd1 <<< 31)) >>> 32;
		if (r > 128'sd2147483647) begin
			sat = 1'b1;
			return SAT_MAX;
		end
		if (r < -128'sd2147483648) begin
			sat = 1'b1;
			return SAT_MIN;
		end
		return r[OUT_W-1:0];
	endfunction

	// evaluate both polynomials for one pixel
	function automatic coord_t warp_pixel(input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] row);
		coord_t c;
		logic signed [127:0] ax, ay, mono;
		logic signed [127:0] xp [4];
		logic signed [127:0] yp [4];
		int ord, k;
		ord = order_reg;
		if (ord < 1) ord = 1;
		if (ord > MAX_ORDER) ord = MAX_ORDER;
		xp[0] = 1; yp[0] = 1;
		for (int i = 1; i < 4; i++) begin
			xp[i] = xp[i-1] * $signed({116'd0, col[COORD_BITS-1:0]});
			yp[i] = yp[i-1] * $signed({116'd0, row[COORD_BITS-1:0]});
		end
		ax = 0; ay = 0; k = 0;
		for (int i = 0; i <= ord; i++)
			for (int j = 0; j + i <= ord; j++) begin
				mono = xp[i] * yp[j];
				ax += 128'(coeff_mem[0][k]) * mono;
				ay += 128'(coeff_mem[1][k]) * mono;
				k++;
			end
		c.sat = 1'b0;
		c.sx = round_q16(ax, c.sat);
		c.sy = round_q16(ay, c.sat);
		return c;
	endfunction

	// random idle gap now and then
	task automatic idle_gap();
		if (gaps_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 16)) @(posedge clk);
	endtask

	// send one request and update the model once it is taken
	task automatic send_item(input logic o, input logic ax, input logic [IDX_W-1:0] idx,
			input logic [COEFF_W-1:0] val, input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] row);
		in_valid <= 1'b1;
		op <= o; coeff_axis <= ax; coeff_index <= idx; coeff_value <= val;
		pixel_col <= col; pixel_row <= row;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (o == OP_LOAD) begin
			if (idx < TERM_CNT) coeff_mem[ax][idx] = val;
		end else
			coord_q.push_back(warp_pixel(col, row));
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic load_coeff(input logic ax, input int idx, input logic [COEFF_W-1:0] val);
		send_item(OP_LOAD, ax, IDX_W'(idx), val, PIX_W'($urandom), PIX_W'($urandom));
	endtask

	task automatic eval_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
		send_item(~OP_LOAD, 1'($urandom), IDX_W'($urandom), {$urandom, $urandom}, col, row);
	endtask

	// drain results and let the pipeline settle before a register write
	task automatic write_order(input logic [ORD_W-1:0] ord);
		in_valid <= 1'b0;
		while (coord_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ord;
		@(posedge clk);
		cfg_we <= 1'b0;
		order_reg = ord;
	endtask

	function automatic logic [COEFF_W-1:0] rand_coeff();
		case ($urandom_range(0, 4))
			0: return {$urandom, $urandom};
			1: return 64'($signed($urandom_range(0, 2000)) - 1000) <<< 48;
			2: return 64'($signed({$urandom, $urandom}) >>> $urandom_range(20, 40));
			3: return 64'($signed({$urandom, $urandom}) >>> $urandom_range(40, 63));
			default: return 64'($signed($urandom_range(0, 200)) - 100) <<< 24;
		endcase
	endfunction

	// extremes of the fields, out-of-range index, every order setting
	task automatic test_directed();
		eval_pixel(12'hfff, 12'hfff);
		load_coeff(0, 0, 64'sh7fff_ffff_ffff_ffff);
		load_coeff(1, 0, 64'sh8000_0000_0000_0000);
		eval_pixel(0, 0);
		load_coeff(0, 1, 64'h0001_0000_0000_0000);
		load_coeff(1, 2, 64'hffff_0000_0000_0000);
		load_coeff(0, 10, 64'h1234_5678_9abc_def0);
		load_coeff(1, 15, '1);
		eval_pixel(12'hfff, 0);
		eval_pixel(0, 12'hfff);
		load_coeff(0, 0, 64'h0000_0000_8000_0000);
		load_coeff(1, 0, 64'hffff_ffff_8000_0000);
		eval_pixel(1, 1);
		for (int i = 3; i < TERM_CNT; i++) load_coeff(i[0], i, 64'h0000_0001_0000_0000);
		for (int o = 0; o < 4; o++) begin
			write_order(ORD_W'(o));
			eval_pixel(12'hfff, 12'hfff);
			eval_pixel(12'h5a5, 12'ha5a);
		end
	endtask

	// random coefficient sets followed by pixel streams
	task automatic test_random(input int items);
		int n;
		n = 0;
		while (n < items) begin
			write_order(ORD_W'($urandom_range(0, 3)));
			repeat ($urandom_range(2, 12)) begin
				load_coeff(1'($urandom), $urandom_range(0, 11), rand_coeff());
				n++;
			end
			repeat ($urandom_range(10, 50)) begin
				if ($urandom_range(0, 1)) eval_pixel(PIX_W'($urandom), PIX_W'($urandom));
				else eval_pixel(PIX_W'($urandom_range(0, 40)), PIX_W'($urandom_range(0, 40)));
				n++;
			end
		end
	endtask

	// output side stalls at random
	always @(posedge clk) begin
		if (gaps_on && $urandom_range(0, 15) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		out_stall <= 1'b0;
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		coord_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (coord_q.size() == 0) begin
				$error("result with no request pending");
				err_cnt++;
			end else begin
				e = coord_q.pop_front();
				if (src_x_q16 !== e.sx) begin
					$error("src_x_q16 expected %0d got %0d", e.sx, src_x_q16);
					err_cnt++;
				end
				if (src_y_q16 !== e.sy) begin
					$error("src_y_q16 expected %0d got %0d", e.sy, src_y_q16);
					err_cnt++;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0d got %0d", e.sat, saturated);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		foreach (coeff_mem[a, k]) coeff_mem[a][k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(800);
		gaps_on = 1'b0;
		test_random(150);
		in_valid <= 1'b0;
		while (coord_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
